// ----- hdl/bpd_pkg.sv -----
// Shared widths and types for the box pair distance pipeline.
package bpd_pkg;

  localparam int COORD_W = 24;
  localparam int SEP_W   = 25;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int RAD_W   = 2 * SEP_W;
  localparam int REM_W   = SEP_W + 1;
  localparam int TRIAL_W = REM_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        gap_t;

  typedef struct packed {
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_b_x;
    coord_t near_b_y;
  } point_set_t;

endpackage

// ----- hdl/bpd_if.sv -----
// Channel interfaces: box pair words in, distance and closest point words out.
interface bpd_in_if;
  import bpd_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_low_x;
  coord_t a_low_y;
  coord_t a_high_x;
  coord_t a_high_y;
  coord_t b_low_x;
  coord_t b_low_y;
  coord_t b_high_x;
  coord_t b_high_y;

  modport source (
    output valid, a_low_x, a_low_y, a_high_x, a_high_y,
           b_low_x, b_low_y, b_high_x, b_high_y,
    input  ready
  );
  modport sink (
    input  valid, a_low_x, a_low_y, a_high_x, a_high_y,
           b_low_x, b_low_y, b_high_x, b_high_y,
    output ready
  );
endinterface

interface bpd_out_if;
  import bpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEP_W-1:0] separation;
  coord_t           near_a_x;
  coord_t           near_a_y;
  coord_t           near_b_x;
  coord_t           near_b_y;

  modport source (
    output valid, separation, near_a_x, near_a_y, near_b_x, near_b_y,
    input  ready
  );
  modport sink (
    input  valid, separation, near_a_x, near_a_y, near_b_x, near_b_y,
    output ready
  );
endinterface

// ----- hdl/bpd_axis.sv -----
// One axis: classifies the pair of intervals, gives the gap and the two closest points.
module bpd_axis (
  input  bpd_pkg::coord_t amin,
  input  bpd_pkg::coord_t amax,
  input  bpd_pkg::coord_t bmin,
  input  bpd_pkg::coord_t bmax,
  output bpd_pkg::gap_t   gap,
  output bpd_pkg::coord_t pa,
  output bpd_pkg::coord_t pb
);
  import bpd_pkg::*;

  logic signed [COORD_W:0] diff_ab;
  logic signed [COORD_W:0] diff_ba;
  logic signed [COORD_W:0] mid_sum;
  logic signed [COORD_W:0] mid_half;
  logic                    a_beyond;
  logic                    b_beyond;

  assign a_beyond = amin > bmax;
  assign b_beyond = bmin > amax;
  assign diff_ab  = {amin[COORD_W-1], amin} - {bmax[COORD_W-1], bmax};
  assign diff_ba  = {bmin[COORD_W-1], bmin} - {amax[COORD_W-1], amax};

  // Midpoint of bmin and amax when bmin >= amin, else of amin and bmax; the arithmetic shift floors.
  assign mid_sum  = (bmin >= amin) ? ({amax[COORD_W-1], amax} + {bmin[COORD_W-1], bmin})
                                   : ({amin[COORD_W-1], amin} + {bmax[COORD_W-1], bmax});
  assign mid_half = mid_sum >>> 1;

  always_comb begin
    if (a_beyond) begin
      gap = diff_ab[COORD_W-1:0];
      pa  = amin;
      pb  = bmax;
    end else if (b_beyond) begin
      gap = diff_ba[COORD_W-1:0];
      pa  = amax;
      pb  = bmin;
    end else begin
      gap = '0;
      pa  = mid_half[COORD_W-1:0];
      pb  = mid_half[COORD_W-1:0];
    end
  end
endmodule

// ----- hdl/bpd_isqrt.sv -----
// Pipelined floor square root, one root bit per stage, closest points carried alongside.
module bpd_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [bpd_pkg::SUM_W-1:0] radicand,
  input  bpd_pkg::point_set_t      in_points,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bpd_pkg::SEP_W-1:0] root,
  output bpd_pkg::point_set_t      out_points
);
  import bpd_pkg::*;

  localparam int STEPS = SEP_W;

  logic                 vld  [STEPS];
  logic                 en   [STEPS];
  logic [REM_W-1:0]     rem  [STEPS];
  logic [SEP_W-1:0]     rt   [STEPS];
  logic [RAD_W-1:0]     rad  [STEPS];
  point_set_t           pts  [STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      logic               v_in;
      logic [REM_W-1:0]   rem_in;
      logic [SEP_W-1:0]   rt_in;
      logic [RAD_W-1:0]   rad_in;
      point_set_t         pts_in;
      logic [TRIAL_W-1:0] trial;
      logic [TRIAL_W:0]   diff;
      logic               en_next;

      if (k == 0) begin : g_first
        assign v_in   = in_valid;
        assign rem_in = '0;
        assign rt_in  = '0;
        assign rad_in = {{(RAD_W-SUM_W){1'b0}}, radicand};
        assign pts_in = in_points;
      end else begin : g_rest
        assign v_in   = vld[k-1];
        assign rem_in = rem[k-1];
        assign rt_in  = rt[k-1];
        assign rad_in = rad[k-1];
        assign pts_in = pts[k-1];
      end

      if (k == STEPS - 1) begin : g_last
        assign en_next = out_ready;
      end else begin : g_mid
        assign en_next = en[k+1];
      end

      // A stage moves when it is empty or its successor takes its word.
      assign en[k] = !vld[k] || en_next;

      assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
      assign diff  = {1'b0, trial} - {2'b00, rt_in, 2'b01};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en[k]) begin
          vld[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rad[k] <= {rad_in[RAD_W-3:0], 2'b00};
          pts[k] <= pts_in;
          if (!diff[TRIAL_W]) begin
            rem[k] <= diff[REM_W-1:0];
            rt[k]  <= {rt_in[SEP_W-2:0], 1'b1};
          end else begin
            rem[k] <= trial[REM_W-1:0];
            rt[k]  <= {rt_in[SEP_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign in_ready   = en[0];
  assign out_valid  = vld[STEPS-1];
  assign root       = rt[STEPS-1];
  assign out_points = pts[STEPS-1];
endmodule

// ----- hdl/box_pair_distance.sv -----
// Top level: distance and closest points between two 2-D axis-aligned boxes.
// Usage:
//   The boxes channel takes one word per box pair: the min and max corners of
//   box A and box B, each coordinate signed Q12.12. The result channel gives one
//   word per pair: the floor square root of the summed squared axis gaps as
//   unsigned Q13.12, and one closest point on each box.
//   The word passes 28 register stages, the first loading at the accepting edge:
//   one stage classifies both axes, one squares the gaps, one sums them, and
//   25 stages each settle one bit of the square root.
//   Throughput is one word per cycle while the receiver takes results; the
//   square root pipeline's one bit per stage sets the depth, not the rate.
//   Every stage holds its own valid bit and moves when it is empty or its
//   successor moves, so bubbles close up and new words are taken while a
//   finished result waits. When the receiver stalls, words stay in place and
//   none is dropped or repeated.
//   Synchronous reset empties the pipeline; no result is pending afterward.
module box_pair_distance (
  input  logic     clk,
  input  logic     rst,
  bpd_in_if.sink   boxes,
  bpd_out_if.source result
);
  import bpd_pkg::*;

  gap_t       gx_c, gy_c;
  point_set_t pts_c;

  logic       v1, v2, v3;
  logic       en1, en2, en3;
  logic       sq_ready;
  gap_t       gx1, gy1;
  point_set_t pts1, pts2, pts3;
  logic [SQ_W-1:0]  sx2, sy2;
  logic [SUM_W-1:0] sum3;

  bpd_axis u_axis_x (
    .amin (boxes.a_low_x),
    .amax (boxes.a_high_x),
    .bmin (boxes.b_low_x),
    .bmax (boxes.b_high_x),
    .gap  (gx_c),
    .pa   (pts_c.near_a_x),
    .pb   (pts_c.near_b_x)
  );

  bpd_axis u_axis_y (
    .amin (boxes.a_low_y),
    .amax (boxes.a_high_y),
    .bmin (boxes.b_low_y),
    .bmax (boxes.b_high_y),
    .gap  (gy_c),
    .pa   (pts_c.near_a_y),
    .pb   (pts_c.near_b_y)
  );

  assign en3 = !v3 || sq_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign boxes.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= boxes.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      gx1  <= gx_c;
      gy1  <= gy_c;
      pts1 <= pts_c;
    end
    if (en2) begin
      sx2  <= gx1 * gx1;
      sy2  <= gy1 * gy1;
      pts2 <= pts1;
    end
    if (en3) begin
      sum3 <= {1'b0, sx2} + {1'b0, sy2};
      pts3 <= pts2;
    end
  end

  point_set_t pts_out;

  bpd_isqrt u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v3),
    .in_ready   (sq_ready),
    .radicand   (sum3),
    .in_points  (pts3),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .root       (result.separation),
    .out_points (pts_out)
  );

  assign result.near_a_x = pts_out.near_a_x;
  assign result.near_a_y = pts_out.near_a_y;
  assign result.near_b_x = pts_out.near_b_x;
  assign result.near_b_y = pts_out.near_b_y;
endmodule
